// ===== src/sbr_pkg.sv =====
// Shared constants, codes and reset values of the scanline bulge remapper.
`default_nettype none

package sbr_pkg;

	// Default sizes handed to the top level parameters.
	localparam int CURVE_DEPTH_DEF = 256;
	localparam int SCREEN_ROWS_DEF = 256;

	// Bitplane geometry.
	localparam int BYTES_PER_ROW = 40;
	localparam int OFFSET_LIMIT  = 10200;

	// Stream widths.
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Input actions.
	localparam logic [1:0] ACT_LOAD_BULGE = 2'd0;
	localparam logic [1:0] ACT_LOAD_BEND  = 2'd1;
	localparam logic [1:0] ACT_COMPUTE    = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_ZOOM_TOP    = 3'd0;
	localparam logic [2:0] REG_ZOOM_BOTTOM = 3'd1;
	localparam logic [2:0] REG_BEND_TOP    = 3'd2;
	localparam logic [2:0] REG_BEND_BOTTOM = 3'd3;
	localparam logic [2:0] REG_ZOOM_PEAK   = 3'd4;
	localparam logic [2:0] REG_BEND_GAIN   = 3'd5;
	localparam logic [2:0] REG_VERT_SHIFT  = 3'd6;
	localparam logic [2:0] REG_BULGE_SIGN  = 3'd7;

	// Register reset values.
	localparam logic signed [9:0] ZOOM_TOP_RST    = -10'sd1;
	localparam logic signed [9:0] ZOOM_BOTTOM_RST = -10'sd1;
	localparam logic signed [9:0] BEND_TOP_RST    = 10'sd0;
	localparam logic signed [9:0] BEND_BOTTOM_RST = 10'sd0;
	localparam logic [7:0]        ZOOM_PEAK_RST   = 8'd1;
	localparam logic signed [7:0] BEND_GAIN_RST   = 8'sd0;
	localparam logic signed [8:0] VERT_SHIFT_RST  = 9'sd0;
	localparam logic signed [1:0] BULGE_SIGN_RST  = 2'sd1;

endpackage

`default_nettype wire

// ===== src/sbr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/scanline_bulge_remap.sv =====
// Top level of the scanline bulge remapper: ramp dividers, curve tables and offset math.
//
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: load or compute fields
// m_axis   out        m_axis_tvalid / m_axis_tready  tuser: updated; tdata: fetch values
// cfg      in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One word is taken per cycle while the output is not stalled; a compute word passes through
// the ramp product register, two stages for each restoring divider (the table
// read runs beside the second divider's last stage), the curve multiply stage, the row clamp
// stage and the offset clamp stage. Load words take effect when they reach the
// table stage, in input order with reads. Reset clears all valid bits and the configuration
// registers; the tables are not cleared. A stalled output freezes the whole pipeline and
// input ready.
`default_nettype none

module scanline_bulge_remap #(
	parameter int CURVE_DEPTH = sbr_pkg::CURVE_DEPTH_DEF,
	parameter int SCREEN_ROWS = sbr_pkg::SCREEN_ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: entry_index[7:0], bulge_entry[18:8], bend_entry[25:19], line_number[33:26],
	//        frame_now[49:34], frame_span[64:50], zero fill[71:65]
	input  wire logic [sbr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: action[1:0]
	input  wire logic [sbr_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// tdata: scroll_control[7:0], fetch_offset[21:8], source_row[29:22], zero fill[31:30]
	output logic [sbr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// tuser: updated[0]
	output logic                                 m_axis_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(CURVE_DEPTH);
	localparam int ROW_W = $clog2(SCREEN_ROWS);

	typedef struct packed {
		logic [1:0]       act;
		logic [IDX_W-1:0] widx;
		logic [10:0]      wdat;
		logic [7:0]       line;
		logic             inz;
		logic             inb;
		logic             skip;
		logic             full;
	} pipe_t;

	// Reduces a table offset below CURVE_DEPTH by conditional subtraction.
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [9:0] v);
		int r;
		r = int'(v);
		for (int k = 5; k >= 0; k--) begin
			if (r >= (CURVE_DEPTH << k)) begin
				r = r - (CURVE_DEPTH << k);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	// Configuration registers.
	logic signed [9:0] zoom_top_q, zoom_bottom_q, bend_top_q, bend_bottom_q;
	logic        [7:0] zoom_peak_q;
	logic signed [7:0] bend_gain_q;
	logic signed [8:0] vert_shift_q;
	logic signed [1:0] bulge_sign_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_top_q    <= sbr_pkg::ZOOM_TOP_RST;
			zoom_bottom_q <= sbr_pkg::ZOOM_BOTTOM_RST;
			bend_top_q    <= sbr_pkg::BEND_TOP_RST;
			bend_bottom_q <= sbr_pkg::BEND_BOTTOM_RST;
			zoom_peak_q   <= sbr_pkg::ZOOM_PEAK_RST;
			bend_gain_q   <= sbr_pkg::BEND_GAIN_RST;
			vert_shift_q  <= sbr_pkg::VERT_SHIFT_RST;
			bulge_sign_q  <= sbr_pkg::BULGE_SIGN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbr_pkg::REG_ZOOM_TOP:    zoom_top_q    <= cfg_data;
				sbr_pkg::REG_ZOOM_BOTTOM: zoom_bottom_q <= cfg_data;
				sbr_pkg::REG_BEND_TOP:    bend_top_q    <= cfg_data;
				sbr_pkg::REG_BEND_BOTTOM: bend_bottom_q <= cfg_data;
				sbr_pkg::REG_ZOOM_PEAK:   zoom_peak_q   <= cfg_data[7:0];
				sbr_pkg::REG_BEND_GAIN:   bend_gain_q   <= cfg_data[7:0];
				sbr_pkg::REG_VERT_SHIFT:  vert_shift_q  <= cfg_data[8:0];
				sbr_pkg::REG_BULGE_SIGN:  bulge_sign_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one; only a stalled output holds it.
	logic adv;
	logic out_valid_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Input word fields.
	logic [1:0]  in_act;
	logic [7:0]  in_entry;
	logic [10:0] in_bulge;
	logic [6:0]  in_bend;
	logic [7:0]  in_line;
	logic [15:0] in_fnow;
	logic [14:0] in_fspan;

	assign in_act   = s_axis_tuser;
	assign in_entry = s_axis_tdata[7:0];
	assign in_bulge = s_axis_tdata[18:8];
	assign in_bend  = s_axis_tdata[25:19];
	assign in_line  = s_axis_tdata[33:26];
	assign in_fnow  = s_axis_tdata[49:34];
	assign in_fspan = s_axis_tdata[64:50];

	// Front end: zone tests, ramp product and load data.
	pipe_t              p0;
	logic               v0;
	logic signed [10:0] line_sx, zdiff0, bdiff0;
	logic [23:0]        num0;

	always_comb begin
		line_sx = signed'({3'b000, in_line});
		zdiff0  = line_sx - 11'(zoom_top_q);
		bdiff0  = line_sx - 11'(bend_top_q);
		num0    = in_fnow * zoom_peak_q;
		v0      = s_axis_tvalid && (in_act == sbr_pkg::ACT_LOAD_BULGE ||
			in_act == sbr_pkg::ACT_LOAD_BEND || in_act == sbr_pkg::ACT_COMPUTE);
		p0.act  = in_act;
		p0.widx = wrap_idx({2'b00, in_entry});
		p0.wdat = (in_act == sbr_pkg::ACT_LOAD_BEND) ? 11'(in_bend) : in_bulge;
		p0.line = in_line;
		p0.inz  = (line_sx >= 11'(zoom_top_q)) && (line_sx < 11'(zoom_bottom_q));
		p0.inb  = (line_sx >= 11'(bend_top_q)) && (line_sx < 11'(bend_bottom_q));
		p0.skip = (vert_shift_q == 9'sd0) && (in_fspan != 15'd0) && !p0.inz && !p0.inb;
		p0.full = in_fnow >= {1'b0, in_fspan};
	end

	// Pipeline registers.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pipe_t       pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s6;
	logic [9:0]  zdiff_s1, bdiff_s1;
	logic [IDX_W-1:0] zidx_s2, bidx_s2, zidx_s3, bidx_s3, zidx_s4, bidx_s4;
	logic [23:0] num_s1, rem_s2;
	logic [14:0] den_s1, den_s2;
	logic [7:0]  q_s2, zoom_s3;
	logic [16:0] rem_s4;
	logic [8:0]  q_s4, scale_s5;
	logic signed [20:0] pb_s6;
	logic signed [15:0] pg_s6;
	logic [ROW_W-1:0]   src_s7;
	logic signed [5:0]  words_s7;
	logic [3:0]  scroll_s7;
	logic        skip_s7;

	// First ramp division, upper quotient bits.
	logic [23:0] r1;
	logic [7:0]  q1;

	always_comb begin
		r1 = num_s1;
		q1 = '0;
		for (int i = 7; i >= 4; i--) begin
			if (r1 >= (24'(den_s1) << i)) begin
				r1    = r1 - (24'(den_s1) << i);
				q1[i] = 1'b1;
			end
		end
	end

	// First ramp division, lower quotient bits; the end of the ramp takes the peak.
	logic [23:0] r2;
	logic [7:0]  q2;
	logic [7:0]  zoom2;

	always_comb begin
		r2 = rem_s2;
		q2 = q_s2;
		for (int i = 3; i >= 0; i--) begin
			if (r2 >= (24'(den_s2) << i)) begin
				r2    = r2 - (24'(den_s2) << i);
				q2[i] = 1'b1;
			end
		end
		zoom2 = pipe_s2.full ? zoom_peak_q : q2;
	end

	// Second division: scale = zoom * 256 / peak, upper bits.
	logic [16:0] r3;
	logic [8:0]  q3;

	always_comb begin
		r3 = {1'b0, zoom_s3, 8'h00};
		q3 = '0;
		for (int i = 8; i >= 4; i--) begin
			if (r3 >= (17'(zoom_peak_q) << i)) begin
				r3    = r3 - (17'(zoom_peak_q) << i);
				q3[i] = 1'b1;
			end
		end
	end

	// Second division, lower bits; a zero peak disables scaling.
	logic [16:0] r4;
	logic [8:0]  q4;
	logic [8:0]  scale4;

	always_comb begin
		r4 = rem_s4;
		q4 = q_s4;
		for (int i = 3; i >= 0; i--) begin
			if (r4 >= (17'(zoom_peak_q) << i)) begin
				r4    = r4 - (17'(zoom_peak_q) << i);
				q4[i] = 1'b1;
			end
		end
		scale4 = (zoom_peak_q == 8'd0) ? 9'd0 : q4;
	end

	// Curve tables: writes and reads happen at the same stage to keep input order.
	logic        bul_we, bend_we, tbl_re;
	logic [10:0] bul_rd;
	logic [6:0]  bend_rd;

	assign bul_we  = adv && v_s4 && (pipe_s4.act == sbr_pkg::ACT_LOAD_BULGE);
	assign bend_we = adv && v_s4 && (pipe_s4.act == sbr_pkg::ACT_LOAD_BEND);
	assign tbl_re  = adv && v_s4 && (pipe_s4.act == sbr_pkg::ACT_COMPUTE);

	sbr_ram #(
		.WIDTH(11),
		.DEPTH(CURVE_DEPTH)
	) u_bulge_ram (
		.clk  (clk),
		.we   (bul_we),
		.waddr(pipe_s4.widx),
		.wdata(pipe_s4.wdat),
		.re   (tbl_re),
		.raddr(zidx_s4),
		.rdata(bul_rd)
	);

	sbr_ram #(
		.WIDTH(7),
		.DEPTH(CURVE_DEPTH)
	) u_bend_ram (
		.clk  (clk),
		.we   (bend_we),
		.waddr(pipe_s4.widx),
		.wdata(pipe_s4.wdat[6:0]),
		.re   (tbl_re),
		.raddr(bidx_s4),
		.rdata(bend_rd)
	);

	// Products of the curve entries.
	logic signed [20:0] pb5;
	logic signed [15:0] pg5;

	always_comb begin
		pb5 = signed'(bul_rd) * signed'({1'b0, scale_s5});
		pg5 = signed'({1'b0, bend_rd}) * bend_gain_q;
	end

	// Source row with clamp, and the bend split into words and fine scroll.
	logic signed [20:0] bo_full;
	logic signed [12:0] bo6;
	logic signed [15:0] sb6, src6;
	logic signed [15:0] xs_full;
	logic signed [9:0]  xs6;
	logic [ROW_W-1:0]   row6;
	logic               bend_on;
	logic signed [5:0]  words6;
	logic [3:0]         scroll6;

	always_comb begin
		bo_full = pb_s6 >>> 8;
		bo6     = bo_full[12:0];
		sb6     = bo6 * bulge_sign_q;
		src6    = signed'({8'h00, pipe_s6.line}) + (pipe_s6.inz ? sb6 : 16'sd0)
			- 16'(vert_shift_q);
		if (src6 < 16'sd0) begin
			row6 = '0;
		end else if (int'(src6) >= SCREEN_ROWS) begin
			row6 = ROW_W'(SCREEN_ROWS - 1);
		end else begin
			row6 = src6[ROW_W-1:0];
		end
		// Floor division by 16 gives the word shift; the low nibble is the matching
		// fine scroll for both shift directions.
		xs_full = pg_s6 >>> 6;
		xs6     = xs_full[9:0];
		bend_on = (bend_gain_q != 8'sd0) && pipe_s6.inb;
		words6  = bend_on ? xs6[9:4] : 6'sd0;
		scroll6 = bend_on ? xs6[3:0] : 4'd0;
	end

	// Byte offset with clamp.
	logic [16:0]        rowoff7;
	logic signed [16:0] off7;
	logic [13:0]        offset7;

	always_comb begin
		rowoff7 = 17'(src_s7) * 17'(sbr_pkg::BYTES_PER_ROW);
		off7    = signed'(rowoff7) - 17'(signed'({words_s7, 1'b0}));
		if (off7 < 17'sd0) begin
			offset7 = '0;
		end else if (int'(off7) > sbr_pkg::OFFSET_LIMIT) begin
			offset7 = 14'(sbr_pkg::OFFSET_LIMIT);
		end else begin
			offset7 = off7[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= v0;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4 && (pipe_s4.act == sbr_pkg::ACT_COMPUTE);
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	logic        upd_q;
	logic [3:0]  scroll_q;
	logic [13:0] offset_q;
	logic [7:0]  row_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s1  <= p0;
			zdiff_s1 <= zdiff0[9:0];
			bdiff_s1 <= bdiff0[9:0];
			num_s1   <= num0;
			den_s1   <= in_fspan;

			pipe_s2  <= pipe_s1;
			zidx_s2  <= wrap_idx(zdiff_s1);
			bidx_s2  <= wrap_idx(bdiff_s1);
			rem_s2   <= r1;
			q_s2     <= q1;
			den_s2   <= den_s1;

			pipe_s3  <= pipe_s2;
			zidx_s3  <= zidx_s2;
			bidx_s3  <= bidx_s2;
			zoom_s3  <= zoom2;

			pipe_s4  <= pipe_s3;
			zidx_s4  <= zidx_s3;
			bidx_s4  <= bidx_s3;
			rem_s4   <= r3;
			q_s4     <= q3;

			pipe_s5  <= pipe_s4;
			scale_s5 <= scale4;

			pipe_s6  <= pipe_s5;
			pb_s6    <= pb5;
			pg_s6    <= pg5;

			src_s7    <= row6;
			words_s7  <= words6;
			scroll_s7 <= scroll6;
			skip_s7   <= pipe_s6.skip;

			upd_q    <= !skip_s7;
			scroll_q <= skip_s7 ? 4'd0 : scroll_s7;
			offset_q <= skip_s7 ? 14'd0 : offset7;
			row_q    <= skip_s7 ? 8'd0 : 8'(src_s7);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = upd_q;
	assign m_axis_tdata  = {2'b00, row_q, offset_q, scroll_q, scroll_q};

endmodule

`default_nettype wire

// ===== src/sbr_checker.sv =====
// Port-level checks of the scanline bulge remapper, bound to its top level.
`default_nettype none

module sbr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [sbr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic                            m_axis_tuser
);

	// A word waiting at the output holds steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// Input is taken whenever the output is not stalled.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stall");

	// A skipped line carries all-zero fetch values.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("skipped line with nonzero fetch values");

	// Both scroll nibbles match and the offset stays within the bitplane.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:4] == m_axis_tdata[3:0]) &&
		(int'(m_axis_tdata[21:8]) <= sbr_pkg::OFFSET_LIMIT))
		else $error("scroll nibbles differ or offset out of range");

endmodule

bind scanline_bulge_remap sbr_checker u_sbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the scanline bulge remapper, driven through its streams.
module tb_top;

	localparam int CURVE_DEPTH  = sbr_pkg::CURVE_DEPTH_DEF;
	localparam int SCREEN_ROWS  = sbr_pkg::SCREEN_ROWS_DEF;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int PHASES       = 13;
	localparam int PHASE_WORDS  = 88;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [1:0]         act;
		logic [7:0]         idx;
		logic signed [10:0] bulge;
		logic [6:0]         bend;
		logic [7:0]         line;
		logic [15:0]        fnow;
		logic [14:0]        fspan;
	} word_t;

	typedef struct packed {
		logic        upd;
		logic [7:0]  scroll;
		logic [13:0] offset;
		logic [7:0]  row;
	} fetch_t;

	typedef struct {
		logic signed [9:0] zoom_top;
		logic signed [9:0] zoom_bottom;
		logic signed [9:0] bend_top;
		logic signed [9:0] bend_bottom;
		logic [7:0]        zoom_peak;
		logic signed [7:0] bend_gain;
		logic signed [8:0] vshift;
		logic signed [1:0] bsign;
	} remap_regs_t;

	typedef struct {
		word_t  w;
		bit     typed;
		fetch_t want;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [sbr_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [sbr_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [sbr_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic                            m_axis_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Predictor state: register copy, curve tables and which entries hold data.
	remap_regs_t        regs;
	logic signed [10:0] bulge_mem [CURVE_DEPTH];
	logic [6:0]         bend_mem [CURVE_DEPTH];
	bit                 bulge_set [CURVE_DEPTH];
	bit                 bend_set [CURVE_DEPTH];
	fetch_t             fetch_due [$];
	dir_row_t           dir_rows [16];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int errors = 0;
	int n_words = 0;
	int n_computes = 0;
	int n_checked = 0;
	int n_settings = 0;
	int cycles = 0;

	scanline_bulge_remap #(
		.CURVE_DEPTH(CURVE_DEPTH),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, fetch_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
	endtask

	function automatic bit bulge_slot(int ln, output int ci);
		int lo, hi;
		lo = regs.zoom_top;
		hi = regs.zoom_bottom;
		ci = (ln - lo) % CURVE_DEPTH;
		return ln >= lo && ln < hi;
	endfunction

	function automatic bit bend_slot(int ln, output int ci);
		int lo, hi;
		lo = regs.bend_top;
		hi = regs.bend_bottom;
		ci = (ln - lo) % CURVE_DEPTH;
		return ln >= lo && ln < hi;
	endfunction

	// Applies one accepted word to the table copies; returns 1 when it yields a fetch result.
	function automatic bit predict_fetch(word_t w, output fetch_t r);
		int ln, fnow, fspan, peak, zoom, scale, src, off;
		int zci, bci, bo, xs, mag, wq, scroll, words;
		bit in_zoom, in_bend;
		r = '0;
		scroll = 0;
		words = 0;
		case (w.act)
			sbr_pkg::ACT_LOAD_BULGE: begin
				bulge_mem[w.idx % CURVE_DEPTH] = w.bulge;
				bulge_set[w.idx % CURVE_DEPTH] = 1'b1;
				return 1'b0;
			end
			sbr_pkg::ACT_LOAD_BEND: begin
				bend_mem[w.idx % CURVE_DEPTH] = w.bend;
				bend_set[w.idx % CURVE_DEPTH] = 1'b1;
				return 1'b0;
			end
			sbr_pkg::ACT_COMPUTE: ;
			default: return 1'b0;
		endcase
		ln = w.line;
		fnow = w.fnow;
		fspan = w.fspan;
		peak = regs.zoom_peak;
		in_zoom = bulge_slot(ln, zci);
		in_bend = bend_slot(ln, bci);
		// Lines outside both zones are skipped unless a shift or a zero span forces an update.
		if (regs.vshift == 0 && fspan > 0 && !in_zoom && !in_bend)
			return 1'b1;
		zoom = (fnow >= fspan) ? peak : (fnow * peak) / fspan;
		scale = (peak == 0) ? 0 : (zoom * 256) / peak;
		if (in_zoom) begin
			bo = (int'(bulge_mem[zci]) * scale) >>> 8;
			src = ln + int'(regs.bsign) * bo - int'(regs.vshift);
		end else begin
			src = ln - int'(regs.vshift);
		end
		if (src < 0)
			src = 0;
		if (src >= SCREEN_ROWS)
			src = SCREEN_ROWS - 1;
		if (regs.bend_gain != 0 && in_bend) begin
			xs = (int'(bend_mem[bci]) * int'(regs.bend_gain)) >>> 6;
			if (xs >= 0) begin
				scroll = xs & 'h0F;
				words = xs / 16;
			end else begin
				// Left shifts round the word count up and scroll back to the right.
				mag = -xs;
				wq = (mag + 15) / 16;
				words = -wq;
				scroll = wq * 16 - mag;
			end
		end
		off = src * sbr_pkg::BYTES_PER_ROW - words * 2;
		if (off < 0)
			off = 0;
		if (off > sbr_pkg::OFFSET_LIMIT)
			off = sbr_pkg::OFFSET_LIMIT;
		r.upd = 1'b1;
		r.scroll = 8'((scroll << 4) | scroll);
		r.offset = 14'(off);
		r.row = 8'(src);
		return 1'b1;
	endfunction

	task automatic send_word(word_t w, bit typed = 1'b0, fetch_t want = '0);
		fetch_t r;
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= sbr_pkg::IN_DATA_W'({$urandom, $urandom, $urandom});
			s_axis_tuser <= sbr_pkg::IN_USER_W'($urandom);
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= w.act;
		s_axis_tdata <= {7'd0, w.fspan, w.fnow, w.line, w.bend, w.bulge, w.idx};
		do @(posedge clk); while (!s_axis_tready);
		if (predict_fetch(w, r)) begin
			fetch_due.push_back(typed ? want : r);
			n_computes++;
		end
		n_words++;
	endtask

	task automatic write_reg(logic [sbr_pkg::CFG_IDX_W-1:0] idx, int val, int width);
		logic [sbr_pkg::CFG_DATA_W-1:0] mask, data;
		mask = sbr_pkg::CFG_DATA_W'((1 << width) - 1);
		// Bits above the register width carry noise and must be ignored.
		data = (sbr_pkg::CFG_DATA_W'($urandom) & ~mask) | (sbr_pkg::CFG_DATA_W'(val) & mask);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sbr_pkg::REG_ZOOM_TOP:    regs.zoom_top = data;
			sbr_pkg::REG_ZOOM_BOTTOM: regs.zoom_bottom = data;
			sbr_pkg::REG_BEND_TOP:    regs.bend_top = data;
			sbr_pkg::REG_BEND_BOTTOM: regs.bend_bottom = data;
			sbr_pkg::REG_ZOOM_PEAK:   regs.zoom_peak = data[7:0];
			sbr_pkg::REG_BEND_GAIN:   regs.bend_gain = data[7:0];
			sbr_pkg::REG_VERT_SHIFT:  regs.vshift = data[8:0];
			sbr_pkg::REG_BULGE_SIGN:  regs.bsign = data[1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(int zt, int zb, int bt, int bb, int peak, int gain, int vs,
			int bs);
		write_reg(sbr_pkg::REG_ZOOM_TOP, zt, 10);
		write_reg(sbr_pkg::REG_ZOOM_BOTTOM, zb, 10);
		write_reg(sbr_pkg::REG_BEND_TOP, bt, 10);
		write_reg(sbr_pkg::REG_BEND_BOTTOM, bb, 10);
		write_reg(sbr_pkg::REG_ZOOM_PEAK, peak, 8);
		write_reg(sbr_pkg::REG_BEND_GAIN, gain, 8);
		write_reg(sbr_pkg::REG_VERT_SHIFT, vs, 9);
		write_reg(sbr_pkg::REG_BULGE_SIGN, bs, 2);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic program_random();
		int zt, zb, bt, bb, peak, gain, vs, bs;
		if ($urandom_range(99) < 80) begin
			zt = int'($urandom_range(264)) - 64;
			zb = zt + int'($urandom_range(120, 1));
		end else begin
			zt = int'($urandom_range(767)) - 256;
			zb = int'($urandom_range(767)) - 256;
		end
		if ($urandom_range(99) < 80) begin
			bt = int'($urandom_range(264)) - 64;
			bb = bt + int'($urandom_range(120, 1));
		end else begin
			bt = int'($urandom_range(767)) - 256;
			bb = int'($urandom_range(767)) - 256;
		end
		peak = ($urandom_range(99) < 12) ? 0 : int'($urandom_range(255));
		gain = ($urandom_range(99) < 10) ? 0 : int'($urandom_range(255)) - 128;
		case ($urandom_range(3))
			0, 1: vs = 0;
			2: vs = int'($urandom_range(80)) - 40;
			default: vs = int'($urandom_range(511)) - 256;
		endcase
		bs = int'($urandom_range(3)) - 2;
		program_regs(zt, zb, bt, bb, peak, gain, vs, bs);
	endtask

	// Stops sending, waits for every due result, then lets trailing load words clear
	// the pipeline.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (fetch_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_line();
		int roll, lo, hi;
		roll = $urandom_range(99);
		if (roll < 40) begin
			lo = regs.zoom_top;
			hi = regs.zoom_bottom;
		end else if (roll < 75) begin
			lo = regs.bend_top;
			hi = regs.bend_bottom;
		end else if (roll < 80) begin
			return (roll < 78) ? 0 : 255;
		end else begin
			return $urandom_range(255);
		end
		if (lo < 0)
			lo = 0;
		if (hi > 256)
			hi = 256;
		if (lo >= hi)
			return $urandom_range(255);
		return $urandom_range(hi - 1, lo);
	endfunction

	// A compute word may only read table entries that already hold data.
	task automatic fill_entry(logic [1:0] act, int ci);
		word_t w;
		w.act = act;
		w.idx = 8'(ci);
		w.bulge = 11'($urandom);
		w.bend = 7'($urandom);
		w.line = 8'($urandom);
		w.fnow = 16'($urandom);
		w.fspan = 15'($urandom);
		send_word(w);
	endtask

	task automatic send_random();
		word_t w;
		int roll, fs, ci;
		w.idx = 8'($urandom);
		w.bulge = 11'($urandom);
		w.bend = 7'($urandom);
		w.line = 8'($urandom);
		w.fnow = 16'($urandom);
		w.fspan = 15'($urandom);
		roll = $urandom_range(99);
		if (roll < 20) begin
			w.act = sbr_pkg::ACT_LOAD_BULGE;
			if (roll < 2)
				w.bulge = 11'h400;
			else if (roll < 4)
				w.bulge = 11'h3FF;
		end else if (roll < 35) begin
			w.act = sbr_pkg::ACT_LOAD_BEND;
			if (roll < 22)
				w.bend = 7'd0;
			else if (roll < 24)
				w.bend = 7'h7F;
		end else if (roll < 95) begin
			w.act = sbr_pkg::ACT_COMPUTE;
			w.line = 8'(pick_line());
			roll = $urandom_range(99);
			if (roll < 15)
				w.fspan = '0;
			else if (roll < 22)
				w.fspan = 15'h7FFF;
			else if (roll < 60)
				w.fspan = 15'($urandom_range(64, 1));
			fs = w.fspan;
			roll = $urandom_range(99);
			if (roll < 20)
				w.fnow = 16'($urandom_range(65535, fs));
			else if (roll < 25)
				w.fnow = 16'(fs);
			else if (roll < 30)
				w.fnow = 16'hFFFF;
			else if (fs > 0)
				w.fnow = 16'($urandom_range(fs - 1, 0));
			if (bulge_slot(w.line, ci) && !bulge_set[ci])
				fill_entry(sbr_pkg::ACT_LOAD_BULGE, ci);
			if (bend_slot(w.line, ci) && !bend_set[ci])
				fill_entry(sbr_pkg::ACT_LOAD_BEND, ci);
		end else begin
			w.act = ACT_UNUSED;
		end
		send_word(w);
	endtask

	function automatic dir_row_t row(logic [1:0] act, int idx, int bulge, int bend, int ln,
			int fnow, int fspan, bit typed = 1'b0, int upd = 0, int scroll = 0, int off = 0,
			int srow = 0);
		dir_row_t d;
		d.w.act = act;
		d.w.idx = 8'(idx);
		d.w.bulge = 11'(bulge);
		d.w.bend = 7'(bend);
		d.w.line = 8'(ln);
		d.w.fnow = 16'(fnow);
		d.w.fspan = 15'(fspan);
		d.typed = typed;
		d.want.upd = 1'(upd);
		d.want.scroll = 8'(scroll);
		d.want.offset = 14'(off);
		d.want.row = 8'(srow);
		return d;
	endfunction

	task automatic check_fetch(fetch_t got, fetch_t want, logic [1:0] pad);
		if (got.upd != want.upd)
			report_mismatch("updated", got.upd, want.upd);
		if (got.scroll != want.scroll)
			report_mismatch("scroll_control", got.scroll, want.scroll);
		if (got.offset != want.offset)
			report_mismatch("fetch_offset", got.offset, want.offset);
		if (got.row != want.row)
			report_mismatch("source_row", got.row, want.row);
		if (pad != 2'd0)
			report_mismatch("tdata fill bits", pad, 0);
	endtask

	always @(posedge clk) begin
		fetch_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.upd = m_axis_tuser;
			got.scroll = m_axis_tdata[7:0];
			got.offset = m_axis_tdata[21:8];
			got.row = m_axis_tdata[29:22];
			if (fetch_due.size() == 0)
				report_mismatch("result word with nothing due, source_row", got.row, 0);
			else
				check_fetch(got, fetch_due.pop_front(), m_axis_tdata[31:30]);
			n_checked++;
		end
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		int p, start;
		regs.zoom_top = -10'sd1;
		regs.zoom_bottom = -10'sd1;
		regs.bend_top = 10'sd0;
		regs.bend_bottom = 10'sd0;
		regs.zoom_peak = 8'd1;
		regs.bend_gain = 8'sd0;
		regs.vshift = 9'sd0;
		regs.bsign = 2'sd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset both zones are empty, so only a zero span makes a line update.
		dir_rows = '{
			row(sbr_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0, 1, 1'b1, 0, 0, 0, 0),
			row(sbr_pkg::ACT_COMPUTE, 255, -1, 127, 255, 65535, 32767, 1'b1, 0, 0, 0, 0),
			row(sbr_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0, 0, 1'b1, 1, 0, 0, 0),
			row(sbr_pkg::ACT_COMPUTE, 0, 0, 0, 255, 65535, 0, 1'b1, 1, 0, 10200, 255),
			row(sbr_pkg::ACT_COMPUTE, 0, 0, 0, 128, 12345, 0, 1'b1, 1, 0, 5120, 128),
			row(ACT_UNUSED, 255, -1, 127, 255, 65535, 32767),
			row(sbr_pkg::ACT_LOAD_BULGE, 0, -1024, 0, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BULGE, 255, 1023, 127, 255, 65535, 32767),
			row(sbr_pkg::ACT_LOAD_BULGE, 1, 0, 0, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BULGE, 2, -1, 0, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BEND, 0, 0, 127, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BEND, 255, -1024, 0, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BEND, 1, 0, 64, 0, 0, 0),
			row(sbr_pkg::ACT_LOAD_BEND, 2, 0, 1, 0, 0, 0),
			row(sbr_pkg::ACT_COMPUTE, 3, 5, 9, 77, 100, 0),
			row(sbr_pkg::ACT_COMPUTE, 0, 0, 0, 7, 40000, 32767, 1'b1, 0, 0, 0, 0)
		};
		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				// Both zones cover every line; curve indices wrap past the table end.
				0: program_regs(-256, 511, -256, 511, 255, 127, 0, 1);
				// Strongest left bend with the out-of-range bulge multiplier.
				1: program_regs(0, 4, 0, 4, 255, -128, 0, -2);
				2: program_regs(0, 256, 0, 256, 1, -128, -256, -1);
				// Empty zones, scaling off, largest shift.
				3: program_regs(511, -256, 100, 50, 0, -1, 255, 0);
				default: program_random();
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
				default: begin src_idle_pct = 20; sink_stall_pct = 20; end
			endcase
			start = n_words;
			while (n_words - start < PHASE_WORDS)
				send_random();
		end
		wait_idle();

		$display("run covered %0d words, %0d line computes, %0d register settings",
			n_words, n_computes, n_settings);
		$display("%0d fetch results compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
src/sbr_pkg.sv
src/sbr_ram.sv
src/scanline_bulge_remap.sv
src/sbr_checker.sv
verif/tb_top.sv
